// ===== hw/rtl/twpd_pkg.sv =====
// ----------------------------------------------------------------------------
// twpd_pkg
// Shared types, codes and constants of the tilt window persistence detector.
// ----------------------------------------------------------------------------
package twpd_pkg;

  // Field widths
  localparam int REQ_W       = 2;
  localparam int SAMPLE_W    = 8;
  localparam int WIN_W       = 7;
  localparam int COUNT_W     = 5;
  localparam int TILT_W      = 2;
  localparam int SUM_W       = 13;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  // Calibration and counter limits
  localparam int unsigned CAL_SAMPLES = 20;
  localparam logic [COUNT_W-1:0] CAL_LAST  = COUNT_W'(CAL_SAMPLES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register reset values
  localparam logic             TILT_ENABLE_RST   = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_LOW_RST    = WIN_W'(2);
  localparam logic [WIN_W-1:0] WINDOW_HIGH_RST   = WIN_W'(15);
  localparam logic [COUNT_W-1:0] PERSIST_LIMIT_RST = COUNT_W'(25);

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_DETECT = 2'd0,
    REQ_CAL    = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Tilt codes
  typedef enum logic [TILT_W-1:0] {
    TILT_CLEAR = 2'd0,
    TILT_NEG   = 2'd1,
    TILT_POS   = 2'd2
  } tilt_t;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TILT_ENABLE   = 4'd0,
    REG_WINDOW_LOW    = 4'd1,
    REG_WINDOW_HIGH   = 4'd2,
    REG_PERSIST_LIMIT = 4'd3
  } reg_index_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic               tilt_enable;
    logic [WIN_W-1:0]   window_low;
    logic [WIN_W-1:0]   window_high;
    logic [COUNT_W-1:0] persist_limit;
  } cfg_t;

  // Detector state carried from word to word
  typedef struct packed {
    logic [COUNT_W-1:0]         persist_count;
    tilt_t                      tilt_latch;
    logic signed [SAMPLE_W-1:0] offset_reg;
    logic signed [SUM_W-1:0]    cal_sum;
    logic [COUNT_W-1:0]         cal_count;
  } state_t;

  // Sum divided by 20, truncated toward zero. |sum| <= 2560, so
  // |sum|>>2 <= 640 and (x*205)>>10 gives x/5 exactly for x < 1024.
  function automatic logic signed [SAMPLE_W-1:0] div_by_cal(
      input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-3:0] quarter;
    logic [SUM_W+5:0] prod;
    logic [SAMPLE_W:0] quot;
    mag     = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
    quarter = mag[SUM_W-1:2];
    prod    = (SUM_W+6)'(quarter) * (SUM_W+6)'(205);
    quot    = prod[SAMPLE_W+10:10];
    div_by_cal = sum[SUM_W-1] ? SAMPLE_W'(~quot + (SAMPLE_W+1)'(1))
                              : SAMPLE_W'(quot);
  endfunction

endpackage

// ===== hw/rtl/tilt_window_persistence_detector.sv =====
// ----------------------------------------------------------------------------
// tilt_window_persistence_detector
// Calibrates an X-axis offset and latches a tilt after a debounced window hit.
// ----------------------------------------------------------------------------
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   sample   | sample_valid/_stall   | req_type, sample
//   result   | result_valid/_stall   | tilt_state, offset_value, offset_updated
//   cfg      | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One word per cycle sustained unless the result stalls. Each word passes the
// input register, then the result register, updating the detector state as
// it enters the latter. rst is synchronous and clears both stages, the state
// and the registers to their defaults; sample_stall is high and cfg_ready
// low while rst is high. A stalled result holds the result register, and the
// input register once it is full; sample_stall rises when both stages are
// full and the result is stalled.
module tilt_window_persistence_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic [twpd_pkg::REQ_W-1:0]           req_type,
  input  logic signed [twpd_pkg::SAMPLE_W-1:0] sample,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [twpd_pkg::TILT_W-1:0]          tilt_state,
  output logic signed [twpd_pkg::SAMPLE_W-1:0] offset_value,
  output logic                                 offset_updated,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [twpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [twpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  twpd_pkg::cfg_t   cfg;
  twpd_pkg::state_t state;
  twpd_pkg::state_t state_next;
  logic             updated_next;

  logic                                 s1_valid;
  twpd_pkg::req_t                       s1_req;
  logic signed [twpd_pkg::SAMPLE_W-1:0] s1_sample;
  logic                                 out_load;
  logic                                 advance;

  // Handshake
  assign out_load     = !result_valid || !result_stall;
  assign sample_stall = rst || (s1_valid && !out_load);
  assign advance      = s1_valid && out_load;
  assign cfg_ready    = !rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tilt_enable   <= twpd_pkg::TILT_ENABLE_RST;
      cfg.window_low    <= twpd_pkg::WINDOW_LOW_RST;
      cfg.window_high   <= twpd_pkg::WINDOW_HIGH_RST;
      cfg.persist_limit <= twpd_pkg::PERSIST_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        twpd_pkg::REG_TILT_ENABLE:   cfg.tilt_enable   <= cfg_data[0];
        twpd_pkg::REG_WINDOW_LOW:    cfg.window_low    <= cfg_data[twpd_pkg::WIN_W-1:0];
        twpd_pkg::REG_WINDOW_HIGH:   cfg.window_high   <= cfg_data[twpd_pkg::WIN_W-1:0];
        twpd_pkg::REG_PERSIST_LIMIT: cfg.persist_limit <= cfg_data[twpd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_req    <= twpd_pkg::req_t'(req_type);
      s1_sample <= sample;
    end
  end

  // Datapath
  twpd_core u_core (
    .req_type       (s1_req),
    .sample         (s1_sample),
    .cfg            (cfg),
    .state          (state),
    .state_next     (state_next),
    .offset_updated (updated_next)
  );

  // Detector state, updated as a word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.persist_count <= '0;
      state.tilt_latch    <= twpd_pkg::TILT_CLEAR;
      state.offset_reg    <= '0;
      state.cal_sum       <= '0;
      state.cal_count     <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tilt_state     <= state_next.tilt_latch;
      offset_value   <= state_next.offset_reg;
      offset_updated <= updated_next;
    end
  end

endmodule

// ===== hw/rtl/twpd_core.sv =====
// ----------------------------------------------------------------------------
// twpd_core
// Next-state logic: calibration averaging, window test and persistence count.
// ----------------------------------------------------------------------------
module twpd_core (
  input  twpd_pkg::req_t                      req_type,
  input  logic signed [twpd_pkg::SAMPLE_W-1:0] sample,
  input  twpd_pkg::cfg_t                      cfg,
  input  twpd_pkg::state_t                    state,
  output twpd_pkg::state_t                    state_next,
  output logic                                offset_updated
);

  logic signed [twpd_pkg::SAMPLE_W-1:0] x;
  logic [twpd_pkg::SAMPLE_W-1:0]        mag;
  logic                                 in_window;
  logic signed [twpd_pkg::SUM_W-1:0]    sum_next;

  // Offset-corrected sample, wrapped to 8 bits, and its magnitude
  assign x   = sample - state.offset_reg;
  assign mag = x[twpd_pkg::SAMPLE_W-1] ? (~x + twpd_pkg::SAMPLE_W'(1)) : x;

  // Strictly inside the window; -128 gives 128, above any bound
  assign in_window = (mag > {1'b0, cfg.window_low}) && (mag < {1'b0, cfg.window_high});

  assign sum_next = state.cal_sum + twpd_pkg::SUM_W'(sample);

  always_comb begin
    state_next     = state;
    offset_updated = 1'b0;
    case (req_type)
      twpd_pkg::REQ_DETECT: begin
        if (cfg.tilt_enable) begin
          if (in_window && (state.tilt_latch == twpd_pkg::TILT_CLEAR)) begin
            if (state.persist_count > cfg.persist_limit) begin
              state_next.tilt_latch = x[twpd_pkg::SAMPLE_W-1] ? twpd_pkg::TILT_NEG
                                                             : twpd_pkg::TILT_POS;
            end else if (state.persist_count != twpd_pkg::COUNT_MAX) begin
              state_next.persist_count = state.persist_count + twpd_pkg::COUNT_W'(1);
            end
          end else begin
            state_next.persist_count = '0;
          end
        end
      end
      twpd_pkg::REQ_CAL: begin
        // Twentieth word closes the average and restarts the sum
        if (state.cal_count >= twpd_pkg::CAL_LAST) begin
          state_next.offset_reg = twpd_pkg::div_by_cal(sum_next);
          state_next.cal_sum    = '0;
          state_next.cal_count  = '0;
          offset_updated        = 1'b1;
        end else begin
          state_next.cal_sum   = sum_next;
          state_next.cal_count = state.cal_count + twpd_pkg::COUNT_W'(1);
        end
      end
      twpd_pkg::REQ_CLEAR: begin
        state_next.tilt_latch = twpd_pkg::TILT_CLEAR;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ===== hw/rtl/twpd_checker.sv =====
// ----------------------------------------------------------------------------
// twpd_checker
// Port-level checks on the tilt detector, bound to the top level.
// ----------------------------------------------------------------------------
module twpd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 sample_stall,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic [twpd_pkg::TILT_W-1:0]          tilt_state,
  input logic signed [twpd_pkg::SAMPLE_W-1:0] offset_value,
  input logic                                 offset_updated
);

  // Input side only backs up when a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample_stall without a stalled result");

  // A stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(tilt_state) && $stable(offset_value)
       && $stable(offset_updated)))
    else $error("stalled result word changed");

  // Latch code is never the unused value
  a_tilt_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (tilt_state <= twpd_pkg::TILT_POS))
    else $error("illegal tilt_state");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid right after reset");

endmodule

bind tilt_window_persistence_detector twpd_checker u_twpd_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_stall   (sample_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .tilt_state     (tilt_state),
  .offset_value   (offset_value),
  .offset_updated (offset_updated)
);

// ===== test/tb_tilt_window_persistence_detector.sv =====
// ----------------------------------------------------------------------------
// tb_tilt_window_persistence_detector
// Self-checking testbench of the tilt window persistence detector.
// A scoreboard class predicts every result word from the accepted sample
// words and the register writes. Each result is checked field by field
// against the oldest expected word. The run starts with directed words and
// then runs random phases: debounce runs, calibration batches, clears and
// noise. Every phase uses its own register setting and one of four idling modes.
// ----------------------------------------------------------------------------
module tb_tilt_window_persistence_detector;

  // Expected result word
  typedef struct {
    twpd_pkg::tilt_t                      tilt;
    logic signed [twpd_pkg::SAMPLE_W-1:0] offset;
    logic                                 updated;
  } tilt_result_t;

  // Predictor of the detector plus the queue of expected result words
  class tilt_scoreboard;
    // register copies
    logic                         tilt_enable;
    logic [twpd_pkg::WIN_W-1:0]   window_low;
    logic [twpd_pkg::WIN_W-1:0]   window_high;
    logic [twpd_pkg::COUNT_W-1:0] persist_limit;
    // detector state
    logic [twpd_pkg::COUNT_W-1:0]         persist_count;
    twpd_pkg::tilt_t                      tilt_latch;
    logic signed [twpd_pkg::SAMPLE_W-1:0] offset_reg;
    int                                   cal_sum;
    int                                   cal_count;
    // bookkeeping
    tilt_result_t expected_q[$];
    int errors;
    int words_checked;
    int latch_events;
    int averages_done;
    int reg_writes;

    function void reset_model();
      tilt_enable   = twpd_pkg::TILT_ENABLE_RST;
      window_low    = twpd_pkg::WINDOW_LOW_RST;
      window_high   = twpd_pkg::WINDOW_HIGH_RST;
      persist_limit = twpd_pkg::PERSIST_LIMIT_RST;
      persist_count = '0;
      tilt_latch    = twpd_pkg::TILT_CLEAR;
      offset_reg    = '0;
      cal_sum       = 0;
      cal_count     = 0;
      expected_q.delete();
      errors        = 0;
      words_checked = 0;
      latch_events  = 0;
      averages_done = 0;
      reg_writes    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // register write; unknown indexes are dropped
    function void note_config(logic [twpd_pkg::CFG_INDEX_W-1:0] idx,
                              logic [twpd_pkg::CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        twpd_pkg::REG_TILT_ENABLE:   tilt_enable   = data[0];
        twpd_pkg::REG_WINDOW_LOW:    window_low    = data[twpd_pkg::WIN_W-1:0];
        twpd_pkg::REG_WINDOW_HIGH:   window_high   = data[twpd_pkg::WIN_W-1:0];
        twpd_pkg::REG_PERSIST_LIMIT: persist_limit = data[twpd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // accepted sample word: update the state and queue the expected result
    function void note_input(logic [twpd_pkg::REQ_W-1:0] req,
                             logic signed [twpd_pkg::SAMPLE_W-1:0] raw);
      logic signed [twpd_pkg::SAMPLE_W-1:0] x;
      int                                   mag;
      bit                                   in_window;
      tilt_result_t                         res;
      res.updated = 1'b0;
      case (twpd_pkg::req_t'(req))
        twpd_pkg::REQ_DETECT: begin
          if (tilt_enable) begin
            x = raw - offset_reg;  // wraps to 8 bits
            mag = (x < 0) ? -int'(x) : int'(x);
            in_window = (mag > int'(window_low)) && (mag < int'(window_high));
            if (in_window && tilt_latch == twpd_pkg::TILT_CLEAR) begin
              if (persist_count > persist_limit) begin
                tilt_latch = (x < 0) ? twpd_pkg::TILT_NEG : twpd_pkg::TILT_POS;
                latch_events++;
              end else if (persist_count != twpd_pkg::COUNT_MAX) begin
                persist_count++;
              end
            end else begin
              persist_count = '0;
            end
          end
        end
        twpd_pkg::REQ_CAL: begin
          cal_sum += int'(raw);
          cal_count++;
          if (cal_count >= int'(twpd_pkg::CAL_SAMPLES)) begin
            // signed divide truncates toward zero
            offset_reg  = twpd_pkg::SAMPLE_W'(cal_sum / int'(twpd_pkg::CAL_SAMPLES));
            cal_sum     = 0;
            cal_count   = 0;
            res.updated = 1'b1;
            averages_done++;
          end
        end
        twpd_pkg::REQ_CLEAR: tilt_latch = twpd_pkg::TILT_CLEAR;
        default: ;
      endcase
      res.tilt   = tilt_latch;
      res.offset = offset_reg;
      expected_q.push_back(res);
    endfunction

    // accepted result word against the oldest expectation
    function void check_result(logic [twpd_pkg::TILT_W-1:0] tilt,
                               logic signed [twpd_pkg::SAMPLE_W-1:0] off,
                               logic upd);
      tilt_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result word with no expected word waiting");
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      words_checked++;
      if (tilt !== exp_res.tilt) begin
        $error("tilt_state: expected %0d, actual %0d", exp_res.tilt, tilt);
        errors++;
      end
      if (off !== exp_res.offset) begin
        $error("offset_value: expected %0d, actual %0d", exp_res.offset, off);
        errors++;
      end
      if (upd !== exp_res.updated) begin
        $error("offset_updated: expected %0d, actual %0d", exp_res.updated, upd);
        errors++;
      end
    endfunction
  endclass

  // DUT signals
  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 sample_valid = 1'b0;
  logic                                 sample_stall;
  logic [twpd_pkg::REQ_W-1:0]           req_type = '0;
  logic signed [twpd_pkg::SAMPLE_W-1:0] sample = '0;
  logic                                 result_valid;
  logic                                 result_stall = 1'b0;
  logic [twpd_pkg::TILT_W-1:0]          tilt_state;
  logic signed [twpd_pkg::SAMPLE_W-1:0] offset_value;
  logic                                 offset_updated;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [twpd_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [twpd_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  // idle percentages of the current phase
  int send_idle_pct  = 0;
  int stall_idle_pct = 0;

  tilt_scoreboard sb = new();

  tilt_window_persistence_detector i_dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .req_type       (req_type),
    .sample         (sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .tilt_state     (tilt_state),
    .offset_value   (offset_value),
    .offset_updated (offset_updated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #3000000;
    $display("tb_tilt_window_persistence_detector failed");
    $finish;
  end

  // Result stall generator
  always @(negedge clk) begin
    result_stall <= (stall_idle_pct != 0) && ($urandom_range(99) < stall_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(tilt_state, offset_value, offset_updated);
  end

  // Send one sample word; called and returns at a falling edge
  task automatic send_word(input logic [twpd_pkg::REQ_W-1:0] req,
                           input logic signed [twpd_pkg::SAMPLE_W-1:0] smp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    req_type     <= req;
    sample       <= smp;
    do @(posedge clk); while (sample_stall);
    sb.note_input(req, smp);
    @(negedge clk);
  endtask

  // One register write; cfg_valid is lowered by the caller
  task automatic write_reg(input logic [twpd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [twpd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
  endtask

  // Full register setting, with junk in the unused data bits
  task automatic set_registers(input bit en, input int lo, input int hi, input int lim);
    write_reg(twpd_pkg::REG_TILT_ENABLE,   {7'($urandom), en});
    write_reg(twpd_pkg::REG_WINDOW_LOW,    {1'($urandom), 7'(lo)});
    write_reg(twpd_pkg::REG_WINDOW_HIGH,   {1'($urandom), 7'(hi)});
    write_reg(twpd_pkg::REG_PERSIST_LIMIT, {3'($urandom), 5'(lim)});
    // write to an index past the register list
    write_reg(twpd_pkg::CFG_INDEX_W'($urandom_range(15, 4)),
              twpd_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain the pipeline before touching the registers
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random phase: debounce runs, calibration batches, clears and noise
  task automatic run_phase(input int n_words, input int snd, input int rcv);
    int  sent;
    int  kind;
    int  len;
    int  mag;
    int  mode;
    int  center;
    bit  neg;
    logic signed [twpd_pkg::SAMPLE_W-1:0] smp;
    logic [twpd_pkg::REQ_W-1:0]           req;
    sent = 0;
    send_idle_pct  = snd;
    stall_idle_pct = rcv;
    while (sent < n_words) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // run of in-window detection words, sometimes broken
        len = $urandom_range(int'(sb.persist_limit) + 4, 1);
        neg = $urandom_range(1);
        for (int i = 0; i < len; i++) begin
          if (int'(sb.window_low) + 1 < int'(sb.window_high) && $urandom_range(9) != 0)
            mag = $urandom_range(int'(sb.window_high) - 1, int'(sb.window_low) + 1);
          else
            mag = $urandom_range(128);
          if ($urandom_range(15) == 0) neg = ~neg;
          smp = twpd_pkg::SAMPLE_W'(int'(sb.offset_reg) + (neg ? -mag : mag));
          send_word(twpd_pkg::REQ_DETECT, smp);
          sent++;
        end
      end else if (kind < 60) begin
        // calibration batch, usually complete
        len    = ($urandom_range(4) == 0) ? $urandom_range(19, 1)
                                          : int'(twpd_pkg::CAL_SAMPLES);
        mode   = $urandom_range(3);
        center = $urandom_range(255) - 128;
        for (int i = 0; i < len; i++) begin
          case (mode)
            0: smp = twpd_pkg::SAMPLE_W'($urandom);
            1: smp = -8'sd128;
            2: smp = 8'sd127;
            default: smp = twpd_pkg::SAMPLE_W'(center + $urandom_range(6) - 3);
          endcase
          send_word(twpd_pkg::REQ_CAL, smp);
          sent++;
        end
      end else if (kind < 70) begin
        send_word(twpd_pkg::REQ_CLEAR, twpd_pkg::SAMPLE_W'($urandom));
        sent++;
      end else begin
        // noise, including the unused request code
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) begin
          req = twpd_pkg::REQ_W'($urandom);
          send_word(req, twpd_pkg::SAMPLE_W'($urandom));
          if (req != twpd_pkg::REQ_NONE) sent++;
        end
      end
    end
    wait_idle();
  endtask

  // Main sequence
  initial begin
    sb.reset_model();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: detection disabled after reset
    send_word(twpd_pkg::REQ_DETECT, 8'sd5);
    send_word(twpd_pkg::REQ_NONE, -8'sd1);
    send_word(twpd_pkg::REQ_CLEAR, 8'sd0);
    wait_idle();

    // directed: shortest debounce, default window
    set_registers(1'b1, 2, 15, 0);
    send_word(twpd_pkg::REQ_DETECT, 8'sd5);     // counter advances
    send_word(twpd_pkg::REQ_DETECT, 8'sd5);     // latches positive, counter kept
    send_word(twpd_pkg::REQ_CLEAR, -8'sd128);   // only the latch drops
    send_word(twpd_pkg::REQ_DETECT, 8'sd5);     // kept counter latches at once
    send_word(twpd_pkg::REQ_DETECT, 8'sd5);     // latched: counter zeroed
    send_word(twpd_pkg::REQ_CLEAR, 8'sd127);
    send_word(twpd_pkg::REQ_DETECT, -8'sd7);
    send_word(twpd_pkg::REQ_DETECT, -8'sd7);    // latches negative
    send_word(twpd_pkg::REQ_CLEAR, 8'sd0);
    send_word(twpd_pkg::REQ_DETECT, -8'sd128);  // magnitude 128, outside
    send_word(twpd_pkg::REQ_DETECT, 8'sd127);
    send_word(twpd_pkg::REQ_DETECT, 8'sd2);     // on the lower bound, outside
    send_word(twpd_pkg::REQ_DETECT, 8'sd15);    // on the upper bound, outside
    send_word(twpd_pkg::REQ_DETECT, 8'sd3);
    send_word(twpd_pkg::REQ_DETECT, -8'sd14);   // latches negative
    send_word(twpd_pkg::REQ_NONE, 8'sd127);
    send_word(twpd_pkg::REQ_CAL, 8'sd127);
    send_word(twpd_pkg::REQ_CAL, -8'sd128);
    wait_idle();

    // random phases over several settings and idling modes
    set_registers(1'b1, 2, 15, 25);
    run_phase(100, 0, 0);
    set_registers(1'b1, 0, 127, 0);
    run_phase(80, 83, 0);
    set_registers(1'b1, 127, 0, 31);  // empty window
    run_phase(60, 0, 83);
    set_registers(1'b0, $urandom_range(127), $urandom_range(127), $urandom_range(31));
    run_phase(60, 18, 18);
    set_registers(1'b1, $urandom_range(20), $urandom_range(127, 20), $urandom_range(31));
    run_phase(100, 0, 0);
    set_registers(1'b1, 1, 40, 31);   // counter saturates, never latches
    run_phase(100, 83, 0);
    set_registers(1'b1, $urandom_range(30), $urandom_range(127, 30), $urandom_range(12));
    run_phase(100, 0, 83);
    set_registers(1'b1, 0, 10, 30);
    run_phase(100, 18, 18);

    // final drain
    send_idle_pct  = 0;
    stall_idle_pct = 0;
    wait_idle();
    repeat (10) @(negedge clk);

    $display("Checked %0d result words; %0d tilt latches, %0d calibration averages,",
             sb.words_checked, sb.latch_events, sb.averages_done);
    $display("%0d register writes over nine settings and four idling modes.", sb.reg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_tilt_window_persistence_detector passed");
    end else begin
      $display("tb_tilt_window_persistence_detector failed");
    end
    $finish;
  end

endmodule
